// ===== hw/rtl/oblu_pkg.sv =====
// ============================================================================
// oblu_pkg
// Shared types and constants for the octagon bound lattice unit.
// ============================================================================
package oblu_pkg;

  // Default sizing
  localparam int DEF_VALUE_WIDTH    = 32;
  localparam int DEF_MAX_THRESHOLDS = 7;

  // Field widths fixed by the interface
  localparam int FUNC_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int COUNT_W   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THR_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_BASE  = 3'd1;

  // Lattice operations; codes 5..7 pass the left bound through
  typedef enum logic [FUNC_W-1:0] {
    FUNC_MEET    = 3'd0,
    FUNC_JOIN    = 3'd1,
    FUNC_WIDEN   = 3'd2,
    FUNC_WIDEN_T = 3'd3,
    FUNC_NARROW  = 3'd4
  } func_t;

endpackage

// ===== hw/rtl/octagon_bound_lattice_unit_top.sv =====
// ============================================================================
// octagon_bound_lattice_unit_top
// Applies one octagon lattice operation to a pair of bound coefficients.
// ============================================================================
// Usage:
//   Input: a beat is taken on each rising edge with start high and busy low.
//   busy is never raised, so a new coefficient pair can enter every cycle.
//   Result: out_valid is high for exactly one cycle per input beat, with
//   out_result_value / out_result_inf; the receiver must take it then.
//   Order: a beat passes the stage 1, stage 2 and output registers and
//   gives its result in input order.
//   Throughput: one beat per cycle, set by the three-stage pipeline
//   (bound compare / threshold compare, first-threshold pick, result mux).
//   Configuration: cfg_we writes register cfg_index (0 = threshold count,
//   1..7 = thresholds) at the edge; write only while no beat is in flight.
//   The count uses the low COUNT_W bits of cfg_wdata, saturating above
//   MAX_THRESHOLDS; writes to thresholds beyond MAX_THRESHOLDS are dropped.
//   Reset: synchronous, active low; clears the pipeline valids, the count
//   and all thresholds to zero.
// ============================================================================
module octagon_bound_lattice_unit_top
  import oblu_pkg::*;
#(
  parameter int VALUE_WIDTH    = DEF_VALUE_WIDTH,
  parameter int MAX_THRESHOLDS = DEF_MAX_THRESHOLDS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          start,
  output logic                          busy,
  input  logic [FUNC_W-1:0]             in_func,
  input  logic signed [VALUE_WIDTH-1:0] in_left_value,
  input  logic                          in_left_inf,
  input  logic signed [VALUE_WIDTH-1:0] in_right_value,
  input  logic                          in_right_inf,
  // result channel
  output logic                          out_valid,
  output logic signed [VALUE_WIDTH-1:0] out_result_value,
  output logic                          out_result_inf,
  // configuration
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [VALUE_WIDTH-1:0]        cfg_wdata
);

  // Configuration registers
  logic        [COUNT_W-1:0]     count_r;
  logic signed [VALUE_WIDTH-1:0] thr_r [MAX_THRESHOLDS];
  logic        [COUNT_W-1:0]     count_wr;

  // Stage 1
  logic                          v1_r;
  func_t                         func1_r;
  logic signed [VALUE_WIDTH-1:0] l1_val_r, r1_val_r;
  logic                          l1_inf_r, r1_inf_r;
  logic                          le1_r, ge1_r;
  logic                          le_nxt, ge_nxt;

  // Stage 2
  logic                          v2_r;
  func_t                         func2_r;
  logic signed [VALUE_WIDTH-1:0] l2_val_r, r2_val_r;
  logic                          l2_inf_r, r2_inf_r;
  logic                          le2_r, ge2_r;
  logic                          pick_found;
  logic signed [VALUE_WIDTH-1:0] pick_value;

  // Stage 3 (output)
  logic                          out_valid_r;
  logic signed [VALUE_WIDTH-1:0] res_val_r;
  logic                          res_inf_r;
  logic signed [VALUE_WIDTH-1:0] res_val_nxt;
  logic                          res_inf_nxt;

  logic                          accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Config write; count saturates at the threshold depth
  assign count_wr = (cfg_wdata[COUNT_W-1:0] > COUNT_W'(MAX_THRESHOLDS)) ?
                    COUNT_W'(MAX_THRESHOLDS) : cfg_wdata[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int j = 0; j < MAX_THRESHOLDS; j++) thr_r[j] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_THR_COUNT) count_r <= count_wr;
      for (int j = 0; j < MAX_THRESHOLDS; j++) begin
        if (cfg_index == CFG_THR_BASE + CFG_IDX_W'(j)) thr_r[j] <= cfg_wdata;
      end
    end
  end

  // Stage 1: left vs right compare, infinity above every finite value
  always_comb begin
    le_nxt = in_right_inf || (!in_left_inf && (in_left_value <= in_right_value));
    ge_nxt = in_left_inf  || (!in_right_inf && (in_left_value >= in_right_value));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= accept;
  end

  always_ff @(posedge clk) begin
    func1_r  <= func_t'(in_func);
    l1_val_r <= in_left_value;
    l1_inf_r <= in_left_inf;
    r1_val_r <= in_right_value;
    r1_inf_r <= in_right_inf;
    le1_r    <= le_nxt;
    ge1_r    <= ge_nxt;
  end

  // Threshold search runs alongside stages 1 and 2
  oblu_thresh_sel #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .MAX_THRESHOLDS (MAX_THRESHOLDS)
  ) u_thresh_sel (
    .clk         (clk),
    .thr         (thr_r),
    .thr_count   (count_r),
    .right_value (in_right_value),
    .right_inf   (in_right_inf),
    .pick_found  (pick_found),
    .pick_value  (pick_value)
  );

  // Stage 2: carry operands to line up with the threshold pick
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    func2_r  <= func1_r;
    l2_val_r <= l1_val_r;
    l2_inf_r <= l1_inf_r;
    r2_val_r <= r1_val_r;
    r2_inf_r <= r1_inf_r;
    le2_r    <= le1_r;
    ge2_r    <= ge1_r;
  end

  // Stage 3: operation select; an infinite result carries a zero value
  always_comb begin
    res_val_nxt = l2_val_r;
    res_inf_nxt = l2_inf_r;
    unique case (func2_r)
      FUNC_MEET: begin
        if (!le2_r) begin
          res_val_nxt = r2_val_r;
          res_inf_nxt = r2_inf_r;
        end
      end
      FUNC_JOIN: begin
        if (!ge2_r) begin
          res_val_nxt = r2_val_r;
          res_inf_nxt = r2_inf_r;
        end
      end
      FUNC_WIDEN: begin
        if (!ge2_r) res_inf_nxt = 1'b1;
      end
      FUNC_WIDEN_T: begin
        if (!ge2_r) begin
          res_val_nxt = pick_value;
          res_inf_nxt = !pick_found;
        end
      end
      FUNC_NARROW: begin
        if (l2_inf_r) begin
          res_val_nxt = r2_val_r;
          res_inf_nxt = r2_inf_r;
        end
      end
      default: begin
        res_val_nxt = l2_val_r;
        res_inf_nxt = l2_inf_r;
      end
    endcase
    if (res_inf_nxt) res_val_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    res_val_r <= res_val_nxt;
    res_inf_r <= res_inf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = res_val_r;
  assign out_result_inf   = res_inf_r;

  // Checks

  // every accepted beat yields exactly one result after the stage 1, stage 2 and output registers
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n, 3) |-> (out_valid == $past(accept, 3)))
    else $error("result strobe does not match accepted beat");

  // an infinite result always reports a zero value
  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_inf) |-> (out_result_value == '0))
    else $error("infinite result with nonzero value");

  // a threshold can only cover a finite right bound
  a_pick_finite: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && pick_found) |-> !r2_inf_r)
    else $error("threshold picked for infinite right bound");

endmodule

// ===== hw/rtl/oblu_thresh_sel.sv =====
// ============================================================================
// oblu_thresh_sel
// Two-stage threshold search: compare the right bound against every active
// threshold, then pick the first threshold in index order that covers it.
// ============================================================================
module oblu_thresh_sel
  import oblu_pkg::*;
#(
  parameter int VALUE_WIDTH    = DEF_VALUE_WIDTH,
  parameter int MAX_THRESHOLDS = DEF_MAX_THRESHOLDS
) (
  input  logic                          clk,
  input  logic signed [VALUE_WIDTH-1:0] thr       [MAX_THRESHOLDS],
  input  logic        [COUNT_W-1:0]     thr_count,
  input  logic signed [VALUE_WIDTH-1:0] right_value,
  input  logic                          right_inf,
  output logic                          pick_found,
  output logic signed [VALUE_WIDTH-1:0] pick_value
);

  logic [MAX_THRESHOLDS-1:0] hit_nxt;
  logic [MAX_THRESHOLDS-1:0] hit_r;
  logic                      found_nxt;
  logic signed [VALUE_WIDTH-1:0] value_nxt;
  logic                      found_r;
  logic signed [VALUE_WIDTH-1:0] value_r;

  // Stage 1: one compare per threshold, masked by the active count
  always_comb begin
    for (int j = 0; j < MAX_THRESHOLDS; j++) begin
      hit_nxt[j] = !right_inf && (right_value <= thr[j]) &&
                   (COUNT_W'(j) < thr_count);
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
  end

  // Stage 2: lowest index wins
  always_comb begin
    found_nxt = 1'b0;
    value_nxt = '0;
    for (int j = MAX_THRESHOLDS - 1; j >= 0; j--) begin
      if (hit_r[j]) begin
        found_nxt = 1'b1;
        value_nxt = thr[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    value_r <= value_nxt;
  end

  assign pick_found = found_r;
  assign pick_value = value_r;

endmodule
